FILE: sv/tod_pkg.sv
// Shared widths, time constants, command codes and reciprocal constants
// for the time-of-day register. No dependencies.
`timescale 1ns / 1ps

package tod_pkg;

  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int TOTAL_W  = 17;  // seconds in a day, 0..86399
  localparam int DIST_W   = 16;
  localparam int OFFSET_W = 32;
  localparam int CMD_W    = 3;

  localparam logic [TOTAL_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [TOTAL_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [TOTAL_W-1:0] HALF_DAY      = 17'd43200;
  localparam logic [TOTAL_W-1:0] SECS_PER_MIN  = 17'd60;

  localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;
  localparam logic [HOUR_W-1:0] HOUR_MAX      = 5'd23;
  localparam logic [MIN_W-1:0]  MINUTE_MAX    = 6'd59;
  localparam logic [SEC_W-1:0]  SECOND_MAX    = 6'd59;

  // 86400 = 128 * 675; the offset is split into low 7 bits and a /675 part.
  localparam logic [9:0]  DIV_675          = 10'd675;
  // ceil(2^35 / 675): exact quotient for dividends below 2^25
  localparam logic [25:0] RECIP_675        = 26'd50903317;
  localparam int          RECIP_675_SHIFT  = 35;
  // ceil(2^29 / 3600): exact for dividends below 86400
  localparam logic [17:0] RECIP_3600       = 18'd149131;
  localparam int          RECIP_3600_SHIFT = 29;
  // ceil(2^17 / 60): exact for dividends below 3600
  localparam logic [11:0] RECIP_60         = 12'd2185;
  localparam int          RECIP_60_SHIFT   = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET = 3'd0,
    CMD_ADD = 3'd1,
    CMD_SUB = 3'd2,
    CMD_INC = 3'd3,
    CMD_DEC = 3'd4,
    CMD_CMP = 3'd5
  } cmd_t;

endpackage

FILE: sv/tod_in_if.sv
// Command channel of the time-of-day register: valid/ready plus one command word.
// Depends on tod_pkg for field widths.
`timescale 1ns / 1ps

interface tod_in_if;
  logic                          valid;
  logic                          ready;
  logic [tod_pkg::CMD_W-1:0]     cmd;
  logic [tod_pkg::HOUR_W-1:0]    given_hour;
  logic [tod_pkg::MIN_W-1:0]     given_minute;
  logic [tod_pkg::SEC_W-1:0]     given_second;
  logic signed [tod_pkg::OFFSET_W-1:0] offset_seconds;

  modport source (
    output valid, cmd, given_hour, given_minute, given_second, offset_seconds,
    input  ready
  );

  modport sink (
    input  valid, cmd, given_hour, given_minute, given_second, offset_seconds,
    output ready
  );
endinterface

FILE: sv/tod_out_if.sv
// Result channel of the time-of-day register: valid/ready plus one result word.
// Depends on tod_pkg for field widths.
`timescale 1ns / 1ps

interface tod_out_if;
  logic                          valid;
  logic                          ready;
  logic [tod_pkg::HOUR_W-1:0]    now_hour;
  logic [tod_pkg::MIN_W-1:0]     now_minute;
  logic [tod_pkg::SEC_W-1:0]     now_second;
  logic [tod_pkg::DIST_W-1:0]    distance;
  logic                          is_less;
  logic                          is_equal;
  logic                          is_greater;
  logic                          bad_argument;

  modport source (
    output valid, now_hour, now_minute, now_second, distance,
           is_less, is_equal, is_greater, bad_argument,
    input  ready
  );

  modport sink (
    input  valid, now_hour, now_minute, now_second, distance,
           is_less, is_equal, is_greater, bad_argument,
    output ready
  );
endinterface

FILE: sv/time_of_day_register.sv
// Time-of-day register (hh:mm:ss, 24 h) with set/add/sub/inc/dec/compare.
// Throughput: one word per cycle while the result side takes words; input register,
// five registered offset steps (reciprocal multiplies for mod 86400, /3600, /60),
// state update into the output register.
// Reset (rst, synchronous): time 00:00:00, pipeline and output empty.
// Depends on tod_pkg, tod_in_if, tod_out_if.
`timescale 1ns / 1ps

module time_of_day_register (
  input  logic      clk,
  input  logic      rst,
  tod_in_if.sink    request,
  tod_out_if.source result
);
  import tod_pkg::*;

  // Fields that ride along with the offset through every stage.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [HOUR_W-1:0] gh;
    logic [MIN_W-1:0]  gm;
    logic [SEC_W-1:0]  gs;
  } common_t;

  // Stage 1: raw command word.
  typedef struct packed {
    common_t             c;
    logic [OFFSET_W-1:0] off;
  } s1_t;

  // Stage 2: |offset| split as q * 128 + low, with q / 675 already formed.
  typedef struct packed {
    common_t     c;
    logic [24:0] q;
    logic [15:0] qq;
    logic [6:0]  low;
    logic        neg;
  } s2_t;

  // Stage 3: offset reduced to 0..86399.
  typedef struct packed {
    common_t            c;
    logic [TOTAL_W-1:0] r;
  } s3_t;

  // Stage 4: hours split off.
  typedef struct packed {
    common_t            c;
    logic [TOTAL_W-1:0] r;
    logic [HOUR_W-1:0]  hh;
  } s4_t;

  // Stage 5: minutes split off, remainder below one hour.
  typedef struct packed {
    common_t           c;
    logic [HOUR_W-1:0] hh;
    logic [MIN_W-1:0]  mm;
    logic [11:0]       rem;
  } s5_t;

  // Stage 6: offset as hh:mm:ss, ready to apply to the stored time.
  typedef struct packed {
    common_t           c;
    logic [HOUR_W-1:0] dh;
    logic [MIN_W-1:0]  dm;
    logic [SEC_W-1:0]  ds;
  } s6_t;

  localparam int NSTAGE = 6;

  // Stored time.
  logic [HOUR_W-1:0] hour_reg, hour_next;
  logic [MIN_W-1:0]  minute_reg, minute_next;
  logic [SEC_W-1:0]  second_reg, second_next;

  // Pipeline control: adv[k] lets stage k+1 load; adv[NSTAGE] is the output register.
  logic [NSTAGE-1:0] stage_valid;
  logic [NSTAGE:0]   adv;
  logic              out_valid;

  s1_t s1;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  s6_t s6, s6_next;

  // ---------------------------------------------------------------------
  // Flow control: a stage may load when empty or when it moves on itself.
  // The output register stalls the pipe while a result word waits and result.ready is low.
  // ---------------------------------------------------------------------
  always_comb begin
    adv[NSTAGE] = !out_valid || result.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      adv[k] = !stage_valid[k] || adv[k+1];
    end
  end

  assign request.ready = adv[0];
  assign result.valid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (adv[0]) begin
        stage_valid[0] <= request.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
      if (adv[NSTAGE]) begin
        out_valid <= stage_valid[NSTAGE-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 -> 2: fold subtract into the sign, take the magnitude,
  // divide its upper 25 bits by 675 with a reciprocal multiply.
  // ---------------------------------------------------------------------
  logic [32:0] off_ext, off_eff, off_mag;
  logic        off_neg;
  logic [50:0] prod_675;

  always_comb begin
    off_ext = {s1.off[OFFSET_W-1], s1.off};
    off_eff = (s1.c.cmd == CMD_SUB) ? (33'd0 - off_ext) : off_ext;
    off_neg = off_eff[32];
    off_mag = off_neg ? (33'd0 - off_eff) : off_eff;  // at most 2^31

    prod_675 = 51'(off_mag[31:7]) * 51'(RECIP_675);

    s2_next.c   = s1.c;
    s2_next.q   = off_mag[31:7];
    s2_next.qq  = prod_675[RECIP_675_SHIFT +: 16];
    s2_next.low = off_mag[6:0];
    s2_next.neg = off_neg;
  end

  // ---------------------------------------------------------------------
  // Stage 2 -> 3: remainder mod 86400, then wrap negative offsets.
  // ---------------------------------------------------------------------
  logic [24:0]        rem_675_wide;
  logic [TOTAL_W-1:0] off_mod;

  always_comb begin
    rem_675_wide = s2.q - 25'(s2.qq) * 25'(DIV_675);
    off_mod      = {rem_675_wide[9:0], s2.low};
    s3_next.c    = s2.c;
    s3_next.r    = (s2.neg && off_mod != '0) ? (SECS_PER_DAY - off_mod) : off_mod;
  end

  // Stage 3 -> 4: hours = r / 3600.
  logic [34:0] prod_3600;

  always_comb begin
    prod_3600  = 35'(s3.r) * 35'(RECIP_3600);
    s4_next.c  = s3.c;
    s4_next.r  = s3.r;
    s4_next.hh = prod_3600[RECIP_3600_SHIFT +: HOUR_W];
  end

  // Stage 4 -> 5: remainder within the hour, minutes = rem / 60.
  logic [TOTAL_W-1:0] rem_hour_wide;
  logic [23:0]        prod_60;

  always_comb begin
    rem_hour_wide = s4.r - 17'(s4.hh) * SECS_PER_HOUR;
    prod_60       = 24'(rem_hour_wide[11:0]) * 24'(RECIP_60);
    s5_next.c     = s4.c;
    s5_next.hh    = s4.hh;
    s5_next.mm    = prod_60[RECIP_60_SHIFT +: MIN_W];
    s5_next.rem   = rem_hour_wide[11:0];
  end

  // Stage 5 -> 6: seconds = rem - 60 * minutes.
  logic [11:0] rem_min_wide;

  always_comb begin
    rem_min_wide = s5.rem - 12'(s5.mm) * 12'(SECS_PER_MIN);
    s6_next.c    = s5.c;
    s6_next.dh   = s5.hh;
    s6_next.dm   = s5.mm;
    s6_next.ds   = rem_min_wide[SEC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1.c.cmd <= request.cmd;
      s1.c.gh  <= request.given_hour;
      s1.c.gm  <= request.given_minute;
      s1.c.gs  <= request.given_second;
      s1.off   <= request.offset_seconds;
    end
    if (adv[1]) s2 <= s2_next;
    if (adv[2]) s3 <= s3_next;
    if (adv[3]) s4 <= s4_next;
    if (adv[4]) s5 <= s5_next;
    if (adv[5]) s6 <= s6_next;
  end

  // ---------------------------------------------------------------------
  // Stage 6: apply the command to the stored time.
  // Add/sub/inc/dec all become a mixed-radix add of an hh:mm:ss offset;
  // decrement is the same as adding 23:59:59.
  // ---------------------------------------------------------------------
  logic [HOUR_W-1:0]  dh;
  logic [MIN_W-1:0]   dm;
  logic [SEC_W-1:0]   ds;
  logic [6:0]         sec_sum, min_sum;
  logic [5:0]         hour_sum;
  logic               sec_carry, min_carry;
  logic [HOUR_W-1:0]  sum_hour;
  logic [MIN_W-1:0]   sum_minute;
  logic [SEC_W-1:0]   sum_second;
  logic               given_ok;
  logic [TOTAL_W-1:0] cur_total, given_total, diff, dist_full;
  logic [DIST_W-1:0]  dist_next;
  logic               lt_next, eq_next, gt_next, bad_next;

  always_comb begin
    case (s6.c.cmd)
      CMD_INC: begin
        dh = '0;
        dm = '0;
        ds = SEC_W'(1);
      end
      CMD_DEC: begin
        dh = HOUR_MAX;
        dm = MINUTE_MAX;
        ds = SECOND_MAX;
      end
      default: begin
        dh = s6.dh;
        dm = s6.dm;
        ds = s6.ds;
      end
    endcase

    sec_sum    = 7'(second_reg) + 7'(ds);
    sec_carry  = sec_sum >= 7'(SECS_PER_MIN);
    sum_second = sec_carry ? 6'(sec_sum - 7'(SECS_PER_MIN)) : sec_sum[SEC_W-1:0];
    min_sum    = 7'(minute_reg) + 7'(dm) + 7'(sec_carry);
    min_carry  = min_sum >= 7'(SECS_PER_MIN);
    sum_minute = min_carry ? 6'(min_sum - 7'(SECS_PER_MIN)) : min_sum[MIN_W-1:0];
    hour_sum   = 6'(hour_reg) + 6'(dh) + 6'(min_carry);
    sum_hour   = (hour_sum >= 6'(HOURS_PER_DAY)) ?
                 5'(hour_sum - 6'(HOURS_PER_DAY)) : hour_sum[HOUR_W-1:0];

    given_ok = (s6.c.gh <= HOUR_MAX) && (s6.c.gm <= MINUTE_MAX) &&
               (s6.c.gs <= SECOND_MAX);

    cur_total   = 17'(hour_reg) * SECS_PER_HOUR + 17'(minute_reg) * SECS_PER_MIN +
                  17'(second_reg);
    given_total = 17'(s6.c.gh) * SECS_PER_HOUR + 17'(s6.c.gm) * SECS_PER_MIN +
                  17'(s6.c.gs);
    diff        = (cur_total > given_total) ? (cur_total - given_total) :
                                              (given_total - cur_total);
    dist_full   = (diff > HALF_DAY) ? (SECS_PER_DAY - diff) : diff;

    hour_next   = hour_reg;
    minute_next = minute_reg;
    second_next = second_reg;
    dist_next   = '0;
    lt_next     = 1'b0;
    eq_next     = 1'b0;
    gt_next     = 1'b0;
    bad_next    = 1'b0;

    case (s6.c.cmd)
      CMD_SET: begin
        if (given_ok) begin
          hour_next   = s6.c.gh;
          minute_next = s6.c.gm;
          second_next = s6.c.gs;
        end else begin
          bad_next = 1'b1;
        end
      end
      CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
        hour_next   = sum_hour;
        minute_next = sum_minute;
        second_next = sum_second;
      end
      CMD_CMP: begin
        if (given_ok) begin
          dist_next = dist_full[DIST_W-1:0];
          lt_next   = cur_total < given_total;
          eq_next   = cur_total == given_total;
          gt_next   = cur_total > given_total;
        end else begin
          bad_next = 1'b1;
        end
      end
      default: begin
        // unused codes: time unchanged, flags clear
      end
    endcase
  end

  // State moves together with the word entering the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_reg   <= '0;
      minute_reg <= '0;
      second_reg <= '0;
    end else if (adv[NSTAGE] && stage_valid[NSTAGE-1]) begin
      hour_reg   <= hour_next;
      minute_reg <= minute_next;
      second_reg <= second_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NSTAGE]) begin
      result.now_hour     <= hour_next;
      result.now_minute   <= minute_next;
      result.now_second   <= second_next;
      result.distance     <= dist_next;
      result.is_less      <= lt_next;
      result.is_equal     <= eq_next;
      result.is_greater   <= gt_next;
      result.bad_argument <= bad_next;
    end
  end

`ifndef ASSERT_OFF
  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    (hour_reg <= HOUR_MAX) && (minute_reg <= MINUTE_MAX) && (second_reg <= SECOND_MAX))
    else $error("stored time out of range");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !(adv[NSTAGE] && stage_valid[NSTAGE-1]) |=>
      $stable(hour_reg) && $stable(minute_reg) && $stable(second_reg))
    else $error("stored time changed without a word retiring");

  a_result_shows_state: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.now_hour == hour_reg) && (result.now_minute == minute_reg) &&
                     (result.now_second == second_reg))
    else $error("result time differs from stored time");

  a_order_flags: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> $onehot0({result.is_less, result.is_equal, result.is_greater}))
    else $error("more than one order flag set");

  a_bad_clears: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.bad_argument |->
      (result.distance == '0) && !result.is_less && !result.is_equal && !result.is_greater)
    else $error("compare fields set on bad argument");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (17'(result.distance) <= HALF_DAY))
    else $error("distance above half a day");
`endif

endmodule

FILE: tb/time_of_day_register_test.sv
// Self-checking bench for time_of_day_register: drives command words, predicts each
// result word in-bench and compares on the result channel.
// Depends on tod_pkg, tod_in_if, tod_out_if and the block itself.
`timescale 1ns / 1ps

module time_of_day_register_test;
  import tod_pkg::*;

  // Signed copies of the package time constants; the package ones are unsigned
  // 17-bit and would turn the signed offset math below unsigned.
  localparam int DAY_SECONDS      = int'(SECS_PER_DAY);
  localparam int HOUR_SECONDS     = int'(SECS_PER_HOUR);
  localparam int MINUTE_SECONDS   = int'(SECS_PER_MIN);
  localparam int HALF_DAY_SECONDS = int'(HALF_DAY);

  // Spare command codes: no state change, only the stored time comes back.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int RANDOM_WORDS = 550;
  localparam int MAX_WAIT     = 12;
  localparam int DRAIN_CYCLES = 20;    // headroom after the last expected result word
  localparam int REPORT_LIMIT = 10;
  localparam int DIRECTED_N   = 26;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic [SEC_W-1:0]    second;
    logic [OFFSET_W-1:0] offset;
  } tod_cmd_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [DIST_W-1:0] distance;
    logic              is_less;
    logic              is_equal;
    logic              is_greater;
    logic              bad_argument;
  } tod_reading_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } hms_t;

  // typed = 1: the reading in the row is what must come back; else predict it.
  typedef struct packed {
    bit           typed;
    tod_cmd_t     word;
    tod_reading_t reading;
  } stim_row_t;

  localparam tod_reading_t NO_READING = '0;

  logic clk;
  logic rst;

  tod_in_if  request_ch ();
  tod_out_if result_ch ();

  time_of_day_register u_top (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  // Predicted stored time, updated as each command word is accepted.
  logic [HOUR_W-1:0] clock_hour;
  logic [MIN_W-1:0]  clock_minute;
  logic [SEC_W-1:0]  clock_second;

  tod_reading_t readings_due [$];   // oldest first
  int           fail_count;
  int           results_taken;
  stim_row_t    directed_rows [DIRECTED_N];

  // --------------------------------------------------------------------------
  // Clock, reset and the run-time limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Slowest legal run is well under 0.3 ms; this is several times that.
  initial begin
    #2_000_000;
    $display("time_of_day_register_test: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Time arithmetic
  // --------------------------------------------------------------------------
  function automatic hms_t split_time(input int t);
    hms_t v;
    v.hour   = HOUR_W'(t / HOUR_SECONDS);
    v.minute = MIN_W'((t % HOUR_SECONDS) / MINUTE_SECONDS);
    v.second = SEC_W'(t % MINUTE_SECONDS);
    return v;
  endfunction

  function automatic int clock_total();
    return int'(clock_hour) * HOUR_SECONDS + int'(clock_minute) * MINUTE_SECONDS
           + int'(clock_second);
  endfunction

  // Applies one command word to the predicted clock and returns the reading
  // the block must report for it.
  function automatic tod_reading_t run_command(input tod_cmd_t w);
    tod_reading_t r;
    hms_t         hms;
    int           cur;
    int           given;
    int           shift;
    int           d;
    int           t;
    bit           in_range;
    longint       off;
    r        = NO_READING;
    cur      = clock_total();
    given    = int'(w.hour) * HOUR_SECONDS + int'(w.minute) * MINUTE_SECONDS
               + int'(w.second);
    in_range = (w.hour <= HOUR_MAX) && (w.minute <= MINUTE_MAX) && (w.second <= SECOND_MAX);
    // Offset folded into 0..86399; SV % keeps the dividend's sign, so fix up.
    off      = longint'($signed(w.offset));
    shift    = int'(off % DAY_SECONDS);
    if (shift < 0) shift += DAY_SECONDS;
    t = cur;
    case (w.cmd)
      CMD_SET: begin
        if (in_range) t = given;
        else r.bad_argument = 1'b1;    // stored time left as it was
      end
      CMD_ADD: t = (cur + shift) % DAY_SECONDS;
      CMD_SUB: t = (cur + DAY_SECONDS - shift) % DAY_SECONDS;
      CMD_INC: t = (cur + 1) % DAY_SECONDS;
      CMD_DEC: t = (cur + DAY_SECONDS - 1) % DAY_SECONDS;
      CMD_CMP: begin
        if (in_range) begin
          d = (given > cur) ? given - cur : cur - given;
          if (d > HALF_DAY_SECONDS) d = DAY_SECONDS - d;
          r.distance   = DIST_W'(d);
          r.is_less    = cur < given;
          r.is_equal   = cur == given;
          r.is_greater = cur > given;
        end else begin
          r.bad_argument = 1'b1;
        end
      end
      default: ;                       // spare codes
    endcase
    hms          = split_time(t);
    clock_hour   = hms.hour;
    clock_minute = hms.minute;
    clock_second = hms.second;
    r.hour       = hms.hour;
    r.minute     = hms.minute;
    r.second     = hms.second;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  function automatic tod_cmd_t cmd_word(input logic [CMD_W-1:0] c, input int h, m, s,
                                        input logic [OFFSET_W-1:0] off);
    tod_cmd_t w;
    w.cmd    = c;
    w.hour   = HOUR_W'(h);
    w.minute = MIN_W'(m);
    w.second = SEC_W'(s);
    w.offset = off;
    return w;
  endfunction

  function automatic tod_reading_t reading(input int h, m, s, dist_secs,
                                           input bit lt, eq, gt, bad);
    tod_reading_t r;
    r.hour         = HOUR_W'(h);
    r.minute       = MIN_W'(m);
    r.second       = SEC_W'(s);
    r.distance     = DIST_W'(dist_secs);
    r.is_less      = lt;
    r.is_equal     = eq;
    r.is_greater   = gt;
    r.bad_argument = bad;
    return r;
  endfunction

  // Random command word. Drawn right after the previous word was accepted, so
  // the predicted clock includes every word sent so far; compares aim near it.
  function automatic tod_cmd_t draw_word();
    tod_cmd_t w;
    hms_t     hms;
    longint   off;
    int       pick;
    int       near;
    w.cmd    = CMD_SPARE_7;
    w.hour   = HOUR_W'($urandom);
    w.minute = MIN_W'($urandom);
    w.second = SEC_W'($urandom);
    w.offset = $urandom;
    pick     = $urandom_range(0, 99);
    if      (pick < 18) w.cmd = CMD_SET;
    else if (pick < 33) w.cmd = CMD_ADD;
    else if (pick < 48) w.cmd = CMD_SUB;
    else if (pick < 60) w.cmd = CMD_INC;
    else if (pick < 72) w.cmd = CMD_DEC;
    else if (pick < 96) w.cmd = CMD_CMP;
    else if (pick < 98) w.cmd = CMD_SPARE_6;

    case (w.cmd)
      CMD_SET: begin
        // mostly legal times, a share of them just below the wrap point
        if ($urandom_range(0, 6) != 0) begin
          if ($urandom_range(0, 4) == 0) begin
            w.hour   = HOUR_MAX;
            w.minute = MINUTE_MAX;
            w.second = SEC_W'($urandom_range(50, 59));
          end else begin
            w.hour   = HOUR_W'($urandom_range(0, 23));
            w.minute = MIN_W'($urandom_range(0, 59));
            w.second = SEC_W'($urandom_range(0, 59));
          end
        end
      end
      CMD_ADD, CMD_SUB: begin
        case ($urandom_range(0, 4))
          0: off = longint'($urandom_range(0, 400)) - 200;
          1: begin
            // whole days plus or minus a little; lands near the day boundaries
            off = longint'($urandom_range(0, 24855)) * DAY_SECONDS
                  + longint'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1) != 0) off = -off;
          end
          2: off = longint'($urandom);
          3: begin
            case ($urandom_range(0, 7))
              0: off = 64'sh7FFF_FFFF;
              1: off = 64'sh8000_0000;
              2: off = 0;
              3: off = -1;
              4: off = DAY_SECONDS;
              5: off = -DAY_SECONDS;
              6: off = DAY_SECONDS - 1;
              default: off = -HALF_DAY_SECONDS;
            endcase
          end
          default: off = longint'($urandom_range(0, 2 * DAY_SECONDS)) - DAY_SECONDS;
        endcase
        w.offset = off[OFFSET_W-1:0];
      end
      CMD_CMP: begin
        pick = $urandom_range(0, 19);
        if (pick >= 3) begin           // the rest keep fully random fields
          case (pick % 4)
            0: near = 0;                                   // equal
            1: near = int'($urandom_range(0, 20)) - 10;    // close either side
            2: near = HALF_DAY_SECONDS + int'($urandom_range(0, 2)) - 1;
            default: near = int'($urandom_range(0, DAY_SECONDS - 1));
          endcase
          hms      = split_time(((clock_total() + near) % DAY_SECONDS + DAY_SECONDS)
                                % DAY_SECONDS);
          w.hour   = hms.hour;
          w.minute = hms.minute;
          w.second = hms.second;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  // Per-word wait: every 64 words, the first 16 go back to back.
  function automatic int draw_wait(input int n);
    if ((n % 64) < 16) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Offers one word after a random gap, holds it until taken, then records the
  // reading it must produce. valid only drops when a gap follows.
  task automatic send_word(input tod_cmd_t w, input int n, input bit typed,
                           input tod_reading_t typed_reading);
    int           gap;
    tod_reading_t r;
    gap = draw_wait(n);
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid          <= 1'b1;
    request_ch.cmd            <= w.cmd;
    request_ch.given_hour     <= w.hour;
    request_ch.given_minute   <= w.minute;
    request_ch.given_second   <= w.second;
    request_ch.offset_seconds <= w.offset;
    do @(posedge clk); while (!request_ch.ready);
    // run even for typed rows so the predicted clock stays in step
    r = run_command(w);
    readings_due.push_back(typed ? typed_reading : r);
  endtask

  initial begin
    request_ch.valid          <= 1'b0;
    request_ch.cmd            <= CMD_SET;
    request_ch.given_hour     <= '0;
    request_ch.given_minute   <= '0;
    request_ch.given_second   <= '0;
    request_ch.offset_seconds <= '0;
    clock_hour   = '0;
    clock_minute = '0;
    clock_second = '0;

    // Directed table: wraps, range errors, the half-day compare, offset extremes.
    directed_rows = '{
      '{1'b1, cmd_word(CMD_CMP, 0, 0, 0, 32'h0),   reading(0, 0, 0, 0, 0, 1, 0, 0)},
      '{1'b1, cmd_word(CMD_INC, 0, 0, 0, 32'h0),   reading(0, 0, 1, 0, 0, 0, 0, 0)},
      '{1'b1, cmd_word(CMD_DEC, 0, 0, 0, 32'h0),   reading(0, 0, 0, 0, 0, 0, 0, 0)},
      '{1'b1, cmd_word(CMD_DEC, 0, 0, 0, 32'h0),   reading(23, 59, 59, 0, 0, 0, 0, 0)},
      '{1'b1, cmd_word(CMD_INC, 0, 0, 0, 32'h0),   reading(0, 0, 0, 0, 0, 0, 0, 0)},
      '{1'b1, cmd_word(CMD_SET, 23, 59, 59, 32'h0), reading(23, 59, 59, 0, 0, 0, 0, 0)},
      // out-of-range sets: flagged, time kept
      '{1'b1, cmd_word(CMD_SET, 24, 0, 0, 32'h0),  reading(23, 59, 59, 0, 0, 0, 0, 1)},
      '{1'b1, cmd_word(CMD_SET, 0, 60, 0, 32'h0),  reading(23, 59, 59, 0, 0, 0, 0, 1)},
      '{1'b1, cmd_word(CMD_SET, 0, 0, 60, 32'h0),  reading(23, 59, 59, 0, 0, 0, 0, 1)},
      '{1'b1, cmd_word(CMD_SET, 31, 63, 63, 32'h0), reading(23, 59, 59, 0, 0, 0, 0, 1)},
      // out-of-range compares: flagged, distance and order all zero
      '{1'b1, cmd_word(CMD_CMP, 24, 0, 0, 32'h0),  reading(23, 59, 59, 0, 0, 0, 0, 1)},
      '{1'b1, cmd_word(CMD_CMP, 0, 0, 63, 32'h0),  reading(23, 59, 59, 0, 0, 0, 0, 1)},
      // circular distance across midnight
      '{1'b1, cmd_word(CMD_CMP, 0, 0, 0, 32'h0),   reading(23, 59, 59, 1, 0, 0, 1, 0)},
      '{1'b1, cmd_word(CMD_SET, 12, 0, 0, 32'h0),  reading(12, 0, 0, 0, 0, 0, 0, 0)},
      '{1'b1, cmd_word(CMD_CMP, 0, 0, 0, 32'h0),   reading(12, 0, 0, 43200, 0, 0, 1, 0)},
      '{1'b0, cmd_word(CMD_CMP, 23, 59, 59, 32'h0), NO_READING},
      '{1'b0, cmd_word(CMD_CMP, 0, 0, 1, 32'h0),   NO_READING},
      // offset extremes, most negative included
      '{1'b0, cmd_word(CMD_ADD, 0, 0, 0, 32'h7FFF_FFFF), NO_READING},
      '{1'b0, cmd_word(CMD_ADD, 0, 0, 0, 32'h8000_0000), NO_READING},
      '{1'b0, cmd_word(CMD_SUB, 0, 0, 0, 32'h8000_0000), NO_READING},
      '{1'b0, cmd_word(CMD_SUB, 0, 0, 0, 32'hFFFF_FFFF), NO_READING},
      '{1'b0, cmd_word(CMD_ADD, 0, 0, 0, 32'd86400), NO_READING},
      '{1'b0, cmd_word(CMD_SUB, 0, 0, 0, 32'h0),   NO_READING},
      '{1'b1, cmd_word(CMD_SET, 0, 0, 0, 32'h0),   reading(0, 0, 0, 0, 0, 0, 0, 0)},
      // spare codes: fields must be ignored
      '{1'b1, cmd_word(CMD_SPARE_6, 31, 63, 63, 32'hFFFF_FFFF), reading(0, 0, 0, 0, 0, 0, 0, 0)},
      '{1'b1, cmd_word(CMD_SPARE_7, 5, 5, 5, 32'h1234_5678), reading(0, 0, 0, 0, 0, 0, 0, 0)}
    };

    @(posedge clk);
    while (rst) @(posedge clk);

    for (int i = 0; i < DIRECTED_N; i++)
      send_word(directed_rows[i].word, i, directed_rows[i].typed, directed_rows[i].reading);
    for (int i = 0; i < RANDOM_WORDS; i++)
      send_word(draw_word(), DIRECTED_N + i, 1'b0, NO_READING);
    request_ch.valid <= 1'b0;

    // Drain, then a few more cycles to catch any stray result word.
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("time_of_day_register_test: done, clean");
    end else begin
      $display("time_of_day_register_test: done, errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, same stall pattern as the command side
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(results_taken);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Check each accepted result word against the oldest pending reading.
  always @(posedge clk) begin
    tod_reading_t got;
    tod_reading_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_taken++;
      got = '{result_ch.now_hour, result_ch.now_minute, result_ch.now_second,
              result_ch.distance, result_ch.is_less, result_ch.is_equal,
              result_ch.is_greater, result_ch.bad_argument};
      if (readings_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: result word with nothing pending: %0d:%0d:%0d", $realtime,
                   got.hour, got.minute, got.second);
      end else begin
        want = readings_due.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: word %0d mismatch: want %0d:%0d:%0d dist=%0d lt/eq/gt/bad=%b%b%b%b",
                     $realtime, results_taken,
                     want.hour, want.minute, want.second, want.distance,
                     want.is_less, want.is_equal, want.is_greater, want.bad_argument);
            $display("    got %0d:%0d:%0d dist=%0d lt/eq/gt/bad=%b%b%b%b",
                     got.hour, got.minute, got.second, got.distance,
                     got.is_less, got.is_equal, got.is_greater, got.bad_argument);
          end
        end
      end
    end
  end

  initial begin
    fail_count    = 0;
    results_taken = 0;
  end

endmodule

FILE: time_of_day_register.f
sv/tod_pkg.sv
sv/tod_in_if.sv
sv/tod_out_if.sv
sv/time_of_day_register.sv
tb/time_of_day_register_test.sv
